// ===== design/length_prefixed_name_deframer_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the length-prefixed name deframer
// Same-cycle and next-cycle implication checks, clocked and reset-qualified.
// ---------------------------------------------------------------------------
`ifndef LENGTH_PREFIXED_NAME_DEFRAMER_ASSERT_SVH
`define LENGTH_PREFIXED_NAME_DEFRAMER_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define LPND_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define LPND_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/lpnd_pkg.sv =====
// ---------------------------------------------------------------------------
// lpnd_pkg
// Types and constants shared by the length-prefixed name deframer.
// ---------------------------------------------------------------------------
package lpnd_pkg;

    // input op codes
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_END  = 1'b1;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SKIP_INDEX = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAKE_ALL   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_TAKE   = 2'd2;

    localparam int CFG_DATA_W = 16;
    localparam int CNT_W      = 16;

    // prefix byte encoding
    localparam logic [7:0] PFX_CONT_BIT  = 8'h80;
    localparam logic [7:0] PFX_NONMINIMAL = 8'h80;
    localparam int         PFX_DIGIT_W   = 7;

    typedef struct packed {
        logic             out_valid;
        logic [7:0]       out_byte;
        logic             first_of_component;
        logic             last_of_component;
        logic             empty_component;
        logic             done_res;
        logic             error;
        logic [CNT_W-1:0] total_components;
        logic [CNT_W-1:0] taken_count;
    } result_t;

endpackage

// ===== design/length_prefixed_name_deframer.sv =====
// ---------------------------------------------------------------------------
// length_prefixed_name_deframer
// Splits a byte stream of length-prefixed components, passes on the payload
// of the selected components and reports counts at the end of each name.
// ---------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  s_*       in   s_valid/s_ready    s_op, s_data_byte
//  m_*       out  m_valid/m_ready    m_out_valid .. m_taken_count
//  cfg_*     in   cfg_we             cfg_idx, cfg_wdata
//
// One transfer per cycle in each direction unless m_ready stalls; every input
// transfer yields one result in the next cycle, held in the output register.
// The per-name state updates in the cycle of the input transfer; the output
// register is reloaded while its content is being taken, so a stall on m_ready
// stops the input only while a result waits.
// aresetn (synchronous) clears the state, the output valid and the registers
// to their defaults (take_all set, others zero).
// ---------------------------------------------------------------------------
module length_prefixed_name_deframer
    import lpnd_pkg::*;
#(
    parameter int MAX_PREFIX_BYTES = 3
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // input items
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_op,
    input  logic [7:0]            s_data_byte,
    // results
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_out_valid,
    output logic [7:0]            m_out_byte,
    output logic                  m_first_of_component,
    output logic                  m_last_of_component,
    output logic                  m_empty_component,
    output logic                  m_done_res,
    output logic                  m_error,
    output logic [CNT_W-1:0]      m_total_components,
    output logic [CNT_W-1:0]      m_taken_count
);

    localparam int REM_W = PFX_DIGIT_W * MAX_PREFIX_BYTES;
    localparam int PL_W  = (MAX_PREFIX_BYTES > 1) ? $clog2(MAX_PREFIX_BYTES) : 1;

    // configuration registers
    logic [CNT_W-1:0] skip_index_reg;
    logic             take_all_reg;
    logic [CNT_W-1:0] max_take_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skip_index_reg <= '0;
            take_all_reg   <= 1'b1;
            max_take_reg   <= '0;
        end else if (cfg_we) begin
            unique case (cfg_idx)
                CFG_SKIP_INDEX: skip_index_reg <= cfg_wdata[CNT_W-1:0];
                CFG_TAKE_ALL:   take_all_reg   <= cfg_wdata[0];
                CFG_MAX_TAKE:   max_take_reg   <= cfg_wdata[CNT_W-1:0];
                default:        ;
            endcase
        end
    end

    // per-name state
    logic             in_payload_reg, in_payload_next;
    logic [PL_W-1:0]  prefix_len_reg, prefix_len_next;
    logic [REM_W-1:0] remaining_reg, remaining_next;
    logic [CNT_W-1:0] comp_index_reg, comp_index_next;
    logic [CNT_W-1:0] taken_reg, taken_next;
    logic             bad_reg, bad_next;
    logic             selected_now_reg, selected_now_next;
    logic             first_pending_reg, first_pending_next;

    logic             m_valid_reg;
    result_t          res_reg, res_next;

    logic             s_xfer;
    logic [REM_W-1:0] digit;
    logic [REM_W-1:0] len;
    logic [REM_W-1:0] rem_or;
    logic             sel;
    logic             finish;
    logic             finish_sel;

    assign s_ready = !m_valid_reg || m_ready;
    assign s_xfer  = s_valid && s_ready;

    assign digit  = REM_W'(s_data_byte & ~PFX_CONT_BIT);
    assign rem_or = remaining_reg | digit;
    assign len    = remaining_reg | REM_W'(s_data_byte);
    assign sel    = (comp_index_reg >= skip_index_reg) &&
                    (take_all_reg || (taken_reg < max_take_reg));

    always_comb begin
        in_payload_next    = in_payload_reg;
        prefix_len_next    = prefix_len_reg;
        remaining_next     = remaining_reg;
        comp_index_next    = comp_index_reg;
        taken_next         = taken_reg;
        bad_next           = bad_reg;
        selected_now_next  = selected_now_reg;
        first_pending_next = first_pending_reg;
        finish             = 1'b0;
        finish_sel         = 1'b0;
        res_next           = '0;

        if (s_op == OP_END) begin
            res_next.done_res         = 1'b1;
            res_next.error            = bad_reg || in_payload_reg ||
                                        (prefix_len_reg != '0) ||
                                        (comp_index_reg < skip_index_reg);
            res_next.total_components = comp_index_reg;
            res_next.taken_count      = taken_reg;
            in_payload_next    = 1'b0;
            prefix_len_next    = '0;
            remaining_next     = '0;
            comp_index_next    = '0;
            taken_next         = '0;
            bad_next           = 1'b0;
            selected_now_next  = 1'b0;
            first_pending_next = 1'b0;
        end else if (bad_reg) begin
            // swallow bytes until the end of the name
        end else if (!in_payload_reg) begin
            if ((prefix_len_reg == '0) && (s_data_byte == PFX_NONMINIMAL)) begin
                bad_next = 1'b1;
            end else if ((s_data_byte & PFX_CONT_BIT) != 8'h00) begin
                if (int'(prefix_len_reg) + 1 >= MAX_PREFIX_BYTES) begin
                    bad_next = 1'b1;
                end else begin
                    remaining_next  = rem_or << PFX_DIGIT_W;
                    prefix_len_next = prefix_len_reg + 1'b1;
                end
            end else begin
                prefix_len_next = '0;
                if (len == '0) begin
                    remaining_next           = '0;
                    res_next.empty_component = sel;
                    finish                   = 1'b1;
                    finish_sel               = sel;
                end else begin
                    in_payload_next    = 1'b1;
                    remaining_next     = len;
                    selected_now_next  = sel;
                    first_pending_next = sel;
                end
            end
        end else begin
            if (selected_now_reg) begin
                res_next.out_valid          = 1'b1;
                res_next.out_byte           = s_data_byte;
                res_next.first_of_component = first_pending_reg;
                res_next.last_of_component  = (remaining_reg == REM_W'(1));
            end
            first_pending_next = 1'b0;
            remaining_next     = remaining_reg - 1'b1;
            if (remaining_reg == REM_W'(1)) begin
                in_payload_next   = 1'b0;
                selected_now_next = 1'b0;
                finish            = 1'b1;
                finish_sel        = selected_now_reg;
            end
        end

        // saturating counters on component completion
        if (finish) begin
            if (comp_index_reg != '1) begin
                comp_index_next = comp_index_reg + 1'b1;
            end
            if (finish_sel && (taken_reg != '1)) begin
                taken_next = taken_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_payload_reg    <= 1'b0;
            prefix_len_reg    <= '0;
            remaining_reg     <= '0;
            comp_index_reg    <= '0;
            taken_reg         <= '0;
            bad_reg           <= 1'b0;
            selected_now_reg  <= 1'b0;
            first_pending_reg <= 1'b0;
        end else if (s_xfer) begin
            in_payload_reg    <= in_payload_next;
            prefix_len_reg    <= prefix_len_next;
            remaining_reg     <= remaining_next;
            comp_index_reg    <= comp_index_next;
            taken_reg         <= taken_next;
            bad_reg           <= bad_next;
            selected_now_reg  <= selected_now_next;
            first_pending_reg <= first_pending_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_ready) begin
            m_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            res_reg <= res_next;
        end
    end

    assign m_valid              = m_valid_reg;
    assign m_out_valid          = res_reg.out_valid;
    assign m_out_byte           = res_reg.out_byte;
    assign m_first_of_component = res_reg.first_of_component;
    assign m_last_of_component  = res_reg.last_of_component;
    assign m_empty_component    = res_reg.empty_component;
    assign m_done_res           = res_reg.done_res;
    assign m_error              = res_reg.error;
    assign m_total_components   = res_reg.total_components;
    assign m_taken_count        = res_reg.taken_count;

    // checks
    `include "length_prefixed_name_deframer_assert.svh"

    `LPND_ASSERT_NEXT(a_end_gives_done, aclk, aresetn, s_xfer && (s_op == OP_END), m_valid && m_done_res && (comp_index_reg == '0) && !bad_reg, "end item must yield a done result and clear the name state")
    `LPND_ASSERT_NOW(a_payload_no_prefix, aclk, aresetn, in_payload_reg, prefix_len_reg == '0, "prefix count left over inside payload")
    `LPND_ASSERT_NOW(a_taken_le_total, aclk, aresetn, 1'b1, taken_reg <= comp_index_reg, "taken count exceeds component count")
    `LPND_ASSERT_NOW(a_byte_not_done, aclk, aresetn, m_valid && m_out_valid, !m_done_res && !m_empty_component, "payload byte result carries done or empty mark")

endmodule
